FILE: rtl/grnq_pkg.sv
package grnq_pkg;

  localparam int ActionW    = 2;
  localparam int PosW       = 32;
  localparam int CellSizeW  = 31;
  localparam int IndexW     = 6;
  localparam int KeyW       = 21;
  localparam int DivW       = 33;

  localparam logic [CellSizeW-1:0] CellSizeMin   = 31'd7;
  localparam logic [CellSizeW-1:0] CellSizeReset = 31'd65536;

  localparam logic [ActionW-1:0] ActClear = 2'd0;
  localparam logic [ActionW-1:0] ActLoad  = 2'd1;
  localparam logic [ActionW-1:0] ActQuery = 2'd2;

  typedef struct packed {
    logic                 start;
    logic                 neg;
    logic [DivW-1:0]      mag;
    logic [CellSizeW-1:0] divisor;
  } div_req_t;

endpackage

FILE: rtl/grnq_if.sv
interface grnq_in_if;
  logic                              valid;
  logic                              ready;
  logic [grnq_pkg::ActionW-1:0]      action;
  logic signed [grnq_pkg::PosW-1:0]  pos_x;
  logic signed [grnq_pkg::PosW-1:0]  pos_y;
  logic signed [grnq_pkg::PosW-1:0]  pos_z;
  logic signed [grnq_pkg::PosW-1:0]  radius;

  modport source (output valid, action, pos_x, pos_y, pos_z, radius, input ready);
  modport sink (input valid, action, pos_x, pos_y, pos_z, radius, output ready);
endinterface

interface grnq_out_if;
  logic                         valid;
  logic                         ready;
  logic [grnq_pkg::IndexW-1:0]  point_index;
  logic                         matched;
  logic                         cells_clipped;
  logic                         last;

  modport source (output valid, point_index, matched, cells_clipped, last, input ready);
  modport sink (input valid, point_index, matched, cells_clipped, last, output ready);
endinterface

interface grnq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [grnq_pkg::CellSizeW-1:0]  cell_size;

  modport source (output valid, cell_size, input ready);
  modport sink (input valid, cell_size, output ready);
endinterface

FILE: rtl/grnq_div.sv
module grnq_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  grnq_pkg::div_req_t          req_i,
  output logic                        done_o,
  output logic [grnq_pkg::DivW-1:0]   quot_o
);
  import grnq_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [5:0]           cnt_q;
  logic [DivW-1:0]      dvd_q;
  logic [31:0]          rem_q;
  logic                 neg_q;
  logic [CellSizeW-1:0] dsr_q;
  logic [31:0]          rem_sh;
  logic                 ge;

  assign rem_sh = {rem_q[30:0], dvd_q[DivW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.mag;
      rem_q <= '0;
      neg_q <= req_i.neg;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      dvd_q <= {dvd_q[DivW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? ((rem_q != '0) ? ~dvd_q : (~dvd_q + 33'd1)) : dvd_q;

endmodule

FILE: rtl/grid_radius_neighbor_query.sv
// Fixed-radius neighbour search over up to MAX_POINTS stored 3-D points binned on a
// uniform grid. A load bins the point with three passes of the serial 33-step divider.
// A query makes four divisions, then tests cell and distance of each stored point with
// one shared 32x32 multiplier, then rescans every stored point once for each distinct
// grid cell that holds a match, since results leave in cell-walk order (z, y, x) and
// load order within a cell. Items are taken only when the block is idle; results stall
// on the output without loss.
module grid_radius_neighbor_query #(
  parameter int MAX_POINTS      = 64,
  parameter int MAX_CELL_RADIUS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  grnq_in_if.sink     in_i,
  grnq_out_if.source  out_o,
  grnq_cfg_if.sink    cfg_i
);
  import grnq_pkg::*;

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int W  = 2 * MAX_CELL_RADIUS + 1;
  localparam int WW = $clog2(W + 1);
  localparam int TW = $clog2(W * W * W + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIVS   = 4'd1;
  localparam logic [3:0] S_DIVW   = 4'd2;
  localparam logic [3:0] S_LDWR   = 4'd3;
  localparam logic [3:0] S_QR2A   = 4'd4;
  localparam logic [3:0] S_QR2B   = 4'd5;
  localparam logic [3:0] S_P1RD   = 4'd6;
  localparam logic [3:0] S_P1DAT  = 4'd7;
  localparam logic [3:0] S_P1SQ   = 4'd8;
  localparam logic [3:0] S_P1ACC  = 4'd9;
  localparam logic [3:0] S_P2INIT = 4'd10;
  localparam logic [3:0] S_P2RD   = 4'd11;
  localparam logic [3:0] S_P2CHK  = 4'd12;
  localparam logic [3:0] S_EMPTY  = 4'd13;
  localparam logic [3:0] S_FLUSH  = 4'd14;

  logic [3:0] state_q, state_d;

  logic [CellSizeW-1:0] cell_size_q;
  logic [CW-1:0]        count_q;

  logic [ActionW-1:0] act_q;
  logic [PosW-1:0]    px_q, py_q, pz_q;
  logic [30:0]        rc_q;

  logic [1:0]      div_k_q;
  div_req_t        div_req;
  logic            div_done;
  logic [DivW-1:0] div_quot;

  logic [KeyW-1:0] cx_q, cy_q, cz_q;
  logic [WW-1:0]   cr_q, w_q;
  logic            clip_q;
  logic [63:0]     r2_q;

  logic [PosW-1:0] mem_x [MAX_POINTS];
  logic [PosW-1:0] mem_y [MAX_POINTS];
  logic [PosW-1:0] mem_z [MAX_POINTS];
  logic [3*KeyW-1:0] mem_k [MAX_POINTS];
  logic [TW:0]     mem_t [MAX_POINTS];
  logic [PosW-1:0] rd_x_q, rd_y_q, rd_z_q;
  logic [3*KeyW-1:0] rd_k_q;
  logic [TW:0]     rd_t_q;

  logic [IW-1:0]   idx_q;
  logic            idx_last;
  logic [31:0]     dx_q, dy_q, dz_q;
  logic            inwin_q;
  logic [TW-1:0]   tagc_q;
  logic [1:0]      sq_cnt_q;
  logic [31:0]     mul_a;
  logic [63:0]     prod_q;
  logic [65:0]     acc_q;
  logic [65:0]     total;
  logic            hit_now;

  logic            any_q;
  logic [TW-1:0]   min_q, cur_q, nxt_q;
  logic            hasn_q;
  logic            pend_v_q;
  logic [IW-1:0]   pend_idx_q;

  logic            out_v_q;
  logic [IndexW-1:0] out_idx_q;
  logic            out_m_q, out_c_q, out_l_q;
  logic            out_free;
  logic            out_load;
  logic [IndexW-1:0] ld_idx;
  logic            ld_m, ld_l;

  logic            in_xfer;
  logic            p1_re, p2_re, pt_we, tag_we;

  logic [KeyW-1:0] bx, by, bz, ox, oy, oz;
  logic            win;
  logic [TW-1:0]   tagc;
  logic [31:0]     adx, ady, adz;

  logic            t_hit, t_match, t_upd, stall;
  logic [TW-1:0]   t_val, nxt_n;
  logic            hasn_n;

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? 32'(~d + 33'd1) : d[31:0];
  endfunction

  function automatic logic [DivW-1:0] mag_of(input logic [31:0] p);
    logic [DivW-1:0] e;
    e = {p[31], p};
    return p[31] ? (~e + 33'd1) : e;
  endfunction

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= CellSizeReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      cell_size_q <= (cfg_i.cell_size < CellSizeMin) ? CellSizeMin : cfg_i.cell_size;
    end
  end

  // divider request
  always_comb begin
    div_req.start   = (state_q == S_DIVS);
    div_req.divisor = cell_size_q;
    div_req.neg     = 1'b0;
    div_req.mag     = '0;
    case (div_k_q)
      2'd0: begin
        div_req.neg = px_q[31];
        div_req.mag = mag_of(px_q);
      end
      2'd1: begin
        div_req.neg = py_q[31];
        div_req.mag = mag_of(py_q);
      end
      2'd2: begin
        div_req.neg = pz_q[31];
        div_req.mag = mag_of(pz_q);
      end
      default: begin
        div_req.mag = DivW'(rc_q) + DivW'(cell_size_q) - 33'd1;
      end
    endcase
  end

  grnq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // cell window and walk position of the point just read
  always_comb begin
    bx  = cx_q - KeyW'(cr_q);
    by  = cy_q - KeyW'(cr_q);
    bz  = cz_q - KeyW'(cr_q);
    ox  = rd_k_q[3*KeyW-1:2*KeyW] - bx;
    oy  = rd_k_q[2*KeyW-1:KeyW] - by;
    oz  = rd_k_q[KeyW-1:0] - bz;
    win = (ox < KeyW'(w_q)) && (oy < KeyW'(w_q)) && (oz < KeyW'(w_q));
    tagc = TW'((TW'(oz[WW-1:0]) * TW'(w_q) + TW'(oy[WW-1:0])) * TW'(w_q)
               + TW'(ox[WW-1:0]));
    adx = abs_diff(rd_x_q, px_q);
    ady = abs_diff(rd_y_q, py_q);
    adz = abs_diff(rd_z_q, pz_q);
  end

  always_comb begin
    case (sq_cnt_q)
      2'd0:    mul_a = dx_q;
      2'd1:    mul_a = dy_q;
      default: mul_a = dz_q;
    endcase
    if (state_q == S_QR2A) begin
      mul_a = {1'b0, rc_q};
    end
  end

  assign total   = acc_q + 66'(prod_q);
  assign hit_now = inwin_q && (total <= 66'(r2_q));
  assign idx_last = (CW'(idx_q) + CW'(1)) == count_q;

  assign t_hit   = rd_t_q[TW];
  assign t_val   = rd_t_q[TW-1:0];
  assign t_match = t_hit && (t_val == cur_q);
  assign t_upd   = t_hit && (t_val > cur_q) && (t_val < nxt_q);
  assign nxt_n   = t_upd ? t_val : nxt_q;
  assign hasn_n  = hasn_q || t_upd;
  assign out_free = !out_v_q || out_o.ready;
  assign stall   = t_match && pend_v_q && !out_free;

  assign p1_re  = (state_q == S_P1RD);
  assign p2_re  = (state_q == S_P2RD);
  assign pt_we  = (state_q == S_LDWR);
  assign tag_we = (state_q == S_P1ACC);

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      mem_x[count_q[IW-1:0]] <= px_q;
      mem_y[count_q[IW-1:0]] <= py_q;
      mem_z[count_q[IW-1:0]] <= pz_q;
      mem_k[count_q[IW-1:0]] <= {cx_q, cy_q, cz_q};
    end
    if (p1_re) begin
      rd_x_q <= mem_x[idx_q];
      rd_y_q <= mem_y[idx_q];
      rd_z_q <= mem_z[idx_q];
      rd_k_q <= mem_k[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      mem_t[idx_q] <= {hit_now, tagc_q};
    end
    if (p2_re) begin
      rd_t_q <= mem_t[idx_q];
    end
  end

  // output register
  always_comb begin
    out_load = 1'b0;
    ld_idx   = '0;
    ld_m     = 1'b1;
    ld_l     = 1'b0;
    case (state_q)
      S_P2CHK: begin
        out_load = t_match && pend_v_q && out_free;
        ld_idx   = IndexW'(pend_idx_q);
      end
      S_FLUSH: begin
        out_load = out_free;
        ld_idx   = IndexW'(pend_idx_q);
        ld_l     = 1'b1;
      end
      S_EMPTY: begin
        out_load = out_free;
        ld_m     = 1'b0;
        ld_l     = 1'b1;
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q <= ld_idx;
      out_m_q   <= ld_m;
      out_c_q   <= clip_q;
      out_l_q   <= ld_l;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.point_index   = out_idx_q;
  assign out_o.matched       = out_m_q;
  assign out_o.cells_clipped = out_c_q;
  assign out_o.last          = out_l_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_i.action == ActQuery) begin
            state_d = S_DIVS;
          end else if (in_i.action == ActLoad && count_q < CW'(MAX_POINTS)) begin
            state_d = S_DIVS;
          end
        end
      end
      S_DIVS: state_d = S_DIVW;
      S_DIVW: begin
        if (div_done) begin
          if (act_q == ActLoad && div_k_q == 2'd2) begin
            state_d = S_LDWR;
          end else if (div_k_q == 2'd3) begin
            state_d = S_QR2A;
          end else begin
            state_d = S_DIVS;
          end
        end
      end
      S_LDWR: state_d = S_IDLE;
      S_QR2A: state_d = S_QR2B;
      S_QR2B: state_d = (count_q == '0) ? S_EMPTY : S_P1RD;
      S_P1RD: state_d = S_P1DAT;
      S_P1DAT: state_d = S_P1SQ;
      S_P1SQ: state_d = (sq_cnt_q == 2'd2) ? S_P1ACC : S_P1SQ;
      S_P1ACC: state_d = idx_last ? S_P2INIT : S_P1RD;
      S_P2INIT: state_d = any_q ? S_P2RD : S_EMPTY;
      S_P2RD: state_d = S_P2CHK;
      S_P2CHK: begin
        if (!stall) begin
          state_d = (idx_last && !hasn_n) ? S_FLUSH : S_P2RD;
        end
      end
      S_EMPTY: state_d = out_free ? S_IDLE : S_EMPTY;
      S_FLUSH: state_d = out_free ? S_IDLE : S_FLUSH;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      div_k_q  <= '0;
      idx_q    <= '0;
      sq_cnt_q <= '0;
      any_q    <= 1'b0;
      hasn_q   <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          div_k_q <= '0;
          if (in_xfer && in_i.action == ActClear) begin
            count_q <= '0;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            div_k_q <= div_k_q + 2'd1;
          end
        end
        S_LDWR: count_q <= count_q + CW'(1);
        S_QR2B: begin
          idx_q <= '0;
          any_q <= 1'b0;
        end
        S_P1DAT: sq_cnt_q <= '0;
        S_P1SQ: sq_cnt_q <= sq_cnt_q + 2'd1;
        S_P1ACC: begin
          if (hit_now) begin
            any_q <= 1'b1;
          end
          idx_q <= idx_last ? '0 : idx_q + IW'(1);
        end
        S_P2INIT: begin
          idx_q    <= '0;
          hasn_q   <= 1'b0;
          pend_v_q <= 1'b0;
        end
        S_P2CHK: begin
          if (!stall) begin
            if (t_match) begin
              pend_v_q <= 1'b1;
            end
            if (idx_last) begin
              idx_q  <= '0;
              hasn_q <= 1'b0;
            end else begin
              idx_q  <= idx_q + IW'(1);
              hasn_q <= hasn_n;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q <= in_i.action;
      px_q  <= in_i.pos_x;
      py_q  <= in_i.pos_y;
      pz_q  <= in_i.pos_z;
      rc_q  <= in_i.radius[31] ? '0 : in_i.radius[30:0];
    end
    if (state_q == S_DIVW && div_done) begin
      case (div_k_q)
        2'd0: cx_q <= div_quot[KeyW-1:0];
        2'd1: cy_q <= div_quot[KeyW-1:0];
        2'd2: cz_q <= div_quot[KeyW-1:0];
        default: begin
          if (div_quot > DivW'(MAX_CELL_RADIUS)) begin
            cr_q   <= WW'(MAX_CELL_RADIUS);
            w_q    <= WW'(W);
            clip_q <= 1'b1;
          end else begin
            cr_q   <= div_quot[WW-1:0];
            w_q    <= WW'({div_quot[WW-1:0], 1'b1});
            clip_q <= 1'b0;
          end
        end
      endcase
    end
    prod_q <= mul_a * mul_a;
    if (state_q == S_QR2B) begin
      r2_q  <= prod_q;
      min_q <= '1;
    end
    if (state_q == S_P1DAT) begin
      dx_q    <= adx;
      dy_q    <= ady;
      dz_q    <= adz;
      inwin_q <= win;
      tagc_q  <= tagc;
    end
    if (state_q == S_P1SQ) begin
      acc_q <= (sq_cnt_q == 2'd0) ? '0 : total;
    end
    if (state_q == S_P1ACC && hit_now && tagc_q < min_q) begin
      min_q <= tagc_q;
    end
    if (state_q == S_P2INIT) begin
      cur_q <= min_q;
      nxt_q <= '1;
    end
    if (state_q == S_P2CHK && !stall) begin
      if (t_match) begin
        pend_idx_q <= idx_q;
      end
      if (idx_last) begin
        cur_q <= nxt_n;
        nxt_q <= '1;
      end else begin
        nxt_q <= nxt_n;
      end
    end
  end

endmodule

FILE: rtl/grnq_chk.sv
module grnq_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [grnq_pkg::IndexW-1:0]  point_index,
  input logic                         matched,
  input logic                         cells_clipped,
  input logic                         last
);
  import grnq_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(point_index) && $stable(matched)
      && $stable(cells_clipped) && $stable(last))
    else $error("result changed while stalled");

  a_nomatch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !matched |-> last)
    else $error("no-match item not final");

  a_nomatch_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !matched |-> point_index == '0)
    else $error("no-match item carries an index");

  a_clip_const: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !last ##1 out_valid |-> $stable(cells_clipped))
    else $error("clip flag changed within a query");

endmodule

bind grid_radius_neighbor_query grnq_chk u_grnq_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .point_index   (out_o.point_index),
  .matched       (out_o.matched),
  .cells_clipped (out_o.cells_clipped),
  .last          (out_o.last)
);
